>>> rtl/gcim_pkg.sv
// Shared types, constants and helpers of the grid coordinate / index mapper.
`default_nettype none
package gcim_pkg;

    localparam int CW    = 10;        // coordinate width
    localparam int IW    = 30;        // linear index width
    localparam int EW    = 11;        // extent register width
    localparam int NDIM  = 3;
    localparam int NBIT  = CW * NDIM; // interleave slots
    localparam int PW    = 5;         // interleave position width
    localparam int NBW   = 4;         // per-dimension bit count width
    localparam int QDEPTH = 4;
    localparam int QAW   = 2;

    // item classes, settled at the front
    localparam logic [1:0] CLS_RM_FWD = 2'd0;
    localparam logic [1:0] CLS_RM_INV = 2'd1;
    localparam logic [1:0] CLS_MT_FWD = 2'd2;
    localparam logic [1:0] CLS_MT_INV = 2'd3;

    localparam logic OP_TO_INDEX = 1'b0;
    localparam logic MODE_MORTON = 1'b1;

    // register indexes
    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_EXT_X = 2'd1;
    localparam logic [1:0] REG_EXT_Y = 2'd2;
    localparam logic [1:0] REG_EXT_Z = 2'd3;

    typedef struct packed {
        logic [1:0]    cls;
        logic [CW-1:0] cx;
        logic [CW-1:0] cy;
        logic [CW-1:0] cz;
        logic [IW-1:0] idx;
    } t_item;

    // slot e = b*NDIM + d : bit b of dimension d
    typedef struct packed {
        logic [NBIT-1:0]         use_bits;
        logic [NBIT-1:0][PW-1:0] pos;
    } t_mmap;

    typedef struct packed {
        logic         full;
        logic         empty;
        logic [QAW:0] count;
    } t_qstat;

    // floor(log2(n)), zero for n of 0 or 1
    function automatic logic [NBW-1:0] floor_log2(input logic [EW-1:0] n);
        logic [NBW-1:0] lb;
        lb = '0;
        for (int i = 0; i < EW; i++) begin
            if (n[i]) lb = NBW'(i);
        end
        return lb;
    endfunction

endpackage
`default_nettype wire

>>> rtl/gcim_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`default_nettype none
module gcim_div_pipe #(
    parameter int DW  = 30,
    parameter int VW  = 11,
    parameter int PLW = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire logic [DW-1:0]  i_dividend,
    input  wire logic [VW-1:0]  i_divisor,
    input  wire logic [PLW-1:0] i_payload,
    output logic                o_valid,
    output logic [DW-1:0]       o_quot,
    output logic [VW-1:0]       o_rem,
    output logic [PLW-1:0]      o_payload
);

    logic [VW-1:0]  r_rem [DW];
    logic [DW-1:0]  r_dq  [DW];
    logic           r_v   [DW];
    logic [PLW-1:0] r_pl  [DW];

    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic [VW-1:0]  s_rem;
        logic [DW-1:0]  s_dq;
        logic           s_v;
        logic [PLW-1:0] s_pl;
        logic [VW:0]    trial;
        logic [VW:0]    diff;
        logic           ge;
        logic [VW-1:0]  n_rem;
        logic [DW-1:0]  n_dq;

        if (k == 0) begin : g_first
            assign s_rem = '0;
            assign s_dq  = i_dividend;
            assign s_v   = i_valid;
            assign s_pl  = i_payload;
        end else begin : g_next
            assign s_rem = r_rem[k-1];
            assign s_dq  = r_dq[k-1];
            assign s_v   = r_v[k-1];
            assign s_pl  = r_pl[k-1];
        end

        // shift in the next dividend bit, subtract when it fits
        assign trial = {s_rem, s_dq[DW-1]};
        assign diff  = trial - {1'b0, i_divisor};
        assign ge    = trial >= {1'b0, i_divisor};
        assign n_rem = ge ? diff[VW-1:0] : trial[VW-1:0];
        assign n_dq  = {s_dq[DW-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_dq[k]  <= n_dq;
                r_pl[k]  <= s_pl;
            end
        end
    end

    assign o_valid   = r_v[DW-1];
    assign o_quot    = r_dq[DW-1];
    assign o_rem     = r_rem[DW-1];
    assign o_payload = r_pl[DW-1];

endmodule
`default_nettype wire

>>> rtl/gcim_front.sv
// Front end: classifies incoming beats and holds them in a short queue.
`default_nettype none
module gcim_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_push,
    input  wire logic                      i_operation,
    input  wire logic [gcim_pkg::CW-1:0]   i_coord_x,
    input  wire logic [gcim_pkg::CW-1:0]   i_coord_y,
    input  wire logic [gcim_pkg::CW-1:0]   i_coord_z,
    input  wire logic [gcim_pkg::IW-1:0]   i_linear_index,
    input  wire logic                      i_curve_mode,
    input  wire logic                      i_take,
    output gcim_pkg::t_item                o_item,
    output logic                           o_item_valid,
    output gcim_pkg::t_qstat               o_status
);

    gcim_pkg::t_item r_mem [gcim_pkg::QDEPTH];
    logic [gcim_pkg::QAW-1:0] r_wp;
    logic [gcim_pkg::QAW-1:0] r_rp;
    logic [gcim_pkg::QAW:0]   r_count;
    gcim_pkg::t_item          cls_item;
    logic                     do_push;
    logic                     do_pop;
    logic                     full;
    logic                     empty;

    // classify by mode and direction
    always_comb begin
        cls_item.cx  = i_coord_x;
        cls_item.cy  = i_coord_y;
        cls_item.cz  = i_coord_z;
        cls_item.idx = i_linear_index;
        if (i_curve_mode == gcim_pkg::MODE_MORTON) begin
            cls_item.cls = (i_operation == gcim_pkg::OP_TO_INDEX) ?
                           gcim_pkg::CLS_MT_FWD : gcim_pkg::CLS_MT_INV;
        end else begin
            cls_item.cls = (i_operation == gcim_pkg::OP_TO_INDEX) ?
                           gcim_pkg::CLS_RM_FWD : gcim_pkg::CLS_RM_INV;
        end
    end

    assign full    = r_count == (gcim_pkg::QAW+1)'(gcim_pkg::QDEPTH);
    assign empty   = r_count == '0;
    assign do_push = i_push && !full;
    assign do_pop  = i_take && !empty;

    // queue pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= cls_item;
    end

    assign o_item         = r_mem[r_rp];
    assign o_item_valid   = !empty;
    assign o_status.full  = full;
    assign o_status.empty = empty;
    assign o_status.count = r_count;

endmodule
`default_nettype wire

>>> rtl/gcim_back.sv
// Back end: interleave, row-major multiply and divide pipeline, result register.
`default_nettype none
module gcim_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire gcim_pkg::t_item           i_item,
    input  wire logic                      i_item_valid,
    input  wire logic [gcim_pkg::EW-1:0]   i_extent_x,
    input  wire logic [gcim_pkg::EW-1:0]   i_extent_y,
    input  wire gcim_pkg::t_mmap           i_map,
    input  wire logic                      i_pop,
    output logic                           o_take,
    output logic                           o_empty,
    output logic [gcim_pkg::IW-1:0]        o_index_out,
    output logic [gcim_pkg::CW-1:0]        o_x_out,
    output logic [gcim_pkg::CW-1:0]        o_y_out,
    output logic [gcim_pkg::CW-1:0]        o_z_out
);

    localparam int TW   = 2 * gcim_pkg::CW + 2;        // z*ny + y
    localparam int PL1W = 2 + 2 * gcim_pkg::IW;
    localparam int PL2W = PL1W + gcim_pkg::CW;

    logic adv;

    // stage 1: item taken from the queue
    logic            r1_v;
    gcim_pkg::t_item r1_item;

    // stage 2
    logic                                    r2_v;
    logic [1:0]                              r2_cls;
    logic [TW-1:0]                           r2_t;
    logic [gcim_pkg::CW-1:0]                 r2_cx;
    logic [gcim_pkg::IW-1:0]                 r2_idx;
    logic [gcim_pkg::IW-1:0]                 r2_mres;
    logic [gcim_pkg::NDIM-1:0][gcim_pkg::CW-1:0] r2_mcrd;

    // result register
    logic                    r_out_valid;
    logic [gcim_pkg::IW-1:0] r_index;
    logic [gcim_pkg::CW-1:0] r_x;
    logic [gcim_pkg::CW-1:0] r_y;
    logic [gcim_pkg::CW-1:0] r_z;

    logic [gcim_pkg::NDIM-1:0][gcim_pkg::CW-1:0] crd;
    logic [gcim_pkg::IW-1:0]                     n_mres;
    logic [gcim_pkg::NDIM-1:0][gcim_pkg::CW-1:0] n_mcrd;
    logic [2*gcim_pkg::CW:0]                     zy_prod;
    logic [TW-1:0]                               n_t;
    logic [TW+gcim_pkg::EW-1:0]                  lin_prod;
    logic [gcim_pkg::IW-1:0]                     lin;
    logic [gcim_pkg::EW-1:0]                     div_x;
    logic [gcim_pkg::EW-1:0]                     div_y;

    logic                    d1_v;
    logic [gcim_pkg::IW-1:0] d1_q;
    logic [gcim_pkg::EW-1:0] d1_rem;
    logic [PL1W-1:0]         d1_pl;
    logic [PL1W-1:0]         pl1;
    logic                    d2_v;
    logic [gcim_pkg::IW-1:0] d2_q;
    logic [gcim_pkg::EW-1:0] d2_rem;
    logic [PL2W-1:0]         d2_pl;

    logic [1:0]              f_cls;
    logic [gcim_pkg::IW-1:0] f_fwd;
    logic [gcim_pkg::IW-1:0] f_mcrd;
    logic [gcim_pkg::CW-1:0] f_rem1;

    // the whole pipe moves unless a finished beat waits
    assign adv    = !r_out_valid || i_pop;
    assign o_take = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (adv) begin
            r1_v <= i_item_valid;
            r2_v <= r1_v;
        end
    end

    // Morton interleave in both directions
    assign crd = {r1_item.cz, r1_item.cy, r1_item.cx};
    always_comb begin
        n_mres = '0;
        n_mcrd = '0;
        for (int b = 0; b < gcim_pkg::CW; b++) begin
            for (int d = 0; d < gcim_pkg::NDIM; d++) begin
                for (int j = 0; j < gcim_pkg::IW; j++) begin
                    if (i_map.use_bits[b*gcim_pkg::NDIM+d] &&
                        i_map.pos[b*gcim_pkg::NDIM+d] == gcim_pkg::PW'(j) &&
                        crd[d][b]) begin
                        n_mres[j] = 1'b1;
                    end
                end
                n_mcrd[d][b] = i_map.use_bits[b*gcim_pkg::NDIM+d] &&
                               r1_item.idx[i_map.pos[b*gcim_pkg::NDIM+d]];
            end
        end
    end

    // row-major forward: first product
    assign zy_prod = r1_item.cz * i_extent_y;
    assign n_t     = TW'(zy_prod) + TW'(r1_item.cy);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_item <= i_item;
            r2_cls  <= r1_item.cls;
            r2_t    <= n_t;
            r2_cx   <= r1_item.cx;
            r2_idx  <= r1_item.idx;
            r2_mres <= n_mres;
            r2_mcrd <= n_mcrd;
        end
    end

    // row-major forward: second product, wraps to the index width
    assign lin_prod = r2_t * i_extent_x;
    assign lin      = lin_prod[gcim_pkg::IW-1:0] + gcim_pkg::IW'(r2_cx);

    // a zero extent divides as one
    assign div_x = (i_extent_x == '0) ? gcim_pkg::EW'(1) : i_extent_x;
    assign div_y = (i_extent_y == '0) ? gcim_pkg::EW'(1) : i_extent_y;

    assign pl1 = {r2_cls, (r2_cls == gcim_pkg::CLS_RM_FWD) ? lin : r2_mres, r2_mcrd};

    gcim_div_pipe #(
        .DW (gcim_pkg::IW),
        .VW (gcim_pkg::EW),
        .PLW(PL1W)
    ) u_div_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (adv),
        .i_valid   (r2_v),
        .i_dividend(r2_idx),
        .i_divisor (div_x),
        .i_payload (pl1),
        .o_valid   (d1_v),
        .o_quot    (d1_q),
        .o_rem     (d1_rem),
        .o_payload (d1_pl)
    );

    gcim_div_pipe #(
        .DW (gcim_pkg::IW),
        .VW (gcim_pkg::EW),
        .PLW(PL2W)
    ) u_div_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (adv),
        .i_valid   (d1_v),
        .i_dividend(d1_q),
        .i_divisor (div_y),
        .i_payload ({d1_pl, d1_rem[gcim_pkg::CW-1:0]}),
        .o_valid   (d2_v),
        .o_quot    (d2_q),
        .o_rem     (d2_rem),
        .o_payload (d2_pl)
    );

    assign {f_cls, f_fwd, f_mcrd, f_rem1} = d2_pl;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_index <= '0;
            r_x     <= '0;
            r_y     <= '0;
            r_z     <= '0;
            case (f_cls)
                gcim_pkg::CLS_RM_FWD, gcim_pkg::CLS_MT_FWD: begin
                    r_index <= f_fwd;
                end
                gcim_pkg::CLS_RM_INV: begin
                    r_x <= f_rem1;
                    r_y <= d2_rem[gcim_pkg::CW-1:0];
                    r_z <= d2_q[gcim_pkg::CW-1:0];
                end
                gcim_pkg::CLS_MT_INV: begin
                    r_x <= f_mcrd[gcim_pkg::CW-1:0];
                    r_y <= f_mcrd[2*gcim_pkg::CW-1:gcim_pkg::CW];
                    r_z <= f_mcrd[3*gcim_pkg::CW-1:2*gcim_pkg::CW];
                end
                default: begin
                    r_index <= '0;
                end
            endcase
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_index_out = r_index;
    assign o_x_out     = r_x;
    assign o_y_out     = r_y;
    assign o_z_out     = r_z;

endmodule
`default_nettype wire

>>> rtl/grid_coord_index_mapper.sv
// Top level of the grid coordinate / linear index mapper.
`default_nettype none
// Maps a 3-D coordinate to a linear index or back, direction chosen per beat,
// in row-major or Morton order set by register 0 (extents in registers 1..3,
// APB, byte address 4*i). One beat is taken per cycle while the queue is not
// full. A beat pushed into an empty block passes the four-entry input queue,
// the stage-1 register that takes it from the queue, a register for the
// interleave and the first row-major product, two 30-stage dividers (one
// quotient bit per stage, the second product entering the first stage) that
// give the row-major inverse, and the result register. Every beat takes the
// same path, so results leave in order. A result not popped stalls the
// whole back pipeline; the queue keeps taking beats until it holds four.
module grid_coord_index_mapper #(
    parameter int MAX_DIM_BITS = 10
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // input queue side
    input  wire logic                      push,
    output logic                           full,
    input  wire logic                      i_operation,
    input  wire logic [gcim_pkg::CW-1:0]   i_coord_x,
    input  wire logic [gcim_pkg::CW-1:0]   i_coord_y,
    input  wire logic [gcim_pkg::CW-1:0]   i_coord_z,
    input  wire logic [gcim_pkg::IW-1:0]   i_linear_index,
    // result queue side
    output logic                           empty,
    input  wire logic                      pop,
    output logic [gcim_pkg::IW-1:0]        o_index_out,
    output logic [gcim_pkg::CW-1:0]        o_x_out,
    output logic [gcim_pkg::CW-1:0]        o_y_out,
    output logic [gcim_pkg::CW-1:0]        o_z_out,
    // configuration
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [3:0]                paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic                    r_curve_mode;
    logic [gcim_pkg::EW-1:0] r_extent_x;
    logic [gcim_pkg::EW-1:0] r_extent_y;
    logic [gcim_pkg::EW-1:0] r_extent_z;
    gcim_pkg::t_mmap         r_map;
    gcim_pkg::t_mmap         n_map;
    logic [1:0]              reg_idx;
    logic                    cfg_wr;
    logic [gcim_pkg::NBW-1:0] nb [gcim_pkg::NDIM];
    logic [gcim_pkg::NBW-1:0] fl [gcim_pkg::NDIM];

    gcim_pkg::t_item  q_item;
    logic             q_valid;
    gcim_pkg::t_qstat q_stat;
    logic             take;

    // register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_mode <= 1'b0;
            r_extent_x   <= gcim_pkg::EW'(1);
            r_extent_y   <= gcim_pkg::EW'(1);
            r_extent_z   <= gcim_pkg::EW'(1);
        end else if (cfg_wr) begin
            case (reg_idx)
                gcim_pkg::REG_MODE:  r_curve_mode <= pwdata[0];
                gcim_pkg::REG_EXT_X: r_extent_x   <= pwdata[gcim_pkg::EW-1:0];
                gcim_pkg::REG_EXT_Y: r_extent_y   <= pwdata[gcim_pkg::EW-1:0];
                gcim_pkg::REG_EXT_Z: r_extent_z   <= pwdata[gcim_pkg::EW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            gcim_pkg::REG_MODE:  prdata = {31'd0, r_curve_mode};
            gcim_pkg::REG_EXT_X: prdata = 32'(r_extent_x);
            gcim_pkg::REG_EXT_Y: prdata = 32'(r_extent_y);
            gcim_pkg::REG_EXT_Z: prdata = 32'(r_extent_z);
            default:             prdata = '0;
        endcase
    end

    // bits per dimension, capped
    assign fl[0] = gcim_pkg::floor_log2(r_extent_x);
    assign fl[1] = gcim_pkg::floor_log2(r_extent_y);
    assign fl[2] = gcim_pkg::floor_log2(r_extent_z);
    for (genvar d = 0; d < gcim_pkg::NDIM; d++) begin : g_nb
        assign nb[d] = (int'(fl[d]) > MAX_DIM_BITS) ?
                       gcim_pkg::NBW'(MAX_DIM_BITS) : fl[d];
    end

    // interleave map: slots of lower bits first, then earlier dimensions
    always_comb begin
        logic [gcim_pkg::PW-1:0] p;
        for (int b = 0; b < gcim_pkg::CW; b++) begin
            for (int d = 0; d < gcim_pkg::NDIM; d++) begin
                p = '0;
                for (int k = 0; k < gcim_pkg::NDIM; k++) begin
                    p = p + ((int'(nb[k]) < b) ? gcim_pkg::PW'(nb[k]) :
                                                  gcim_pkg::PW'(b));
                    if (k < d && int'(nb[k]) > b) p = p + 1'b1;
                end
                n_map.use_bits[b*gcim_pkg::NDIM+d] = int'(nb[d]) > b;
                n_map.pos[b*gcim_pkg::NDIM+d]      = p;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_map <= n_map;
    end

    gcim_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_operation   (i_operation),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_linear_index(i_linear_index),
        .i_curve_mode  (r_curve_mode),
        .i_take        (take),
        .o_item        (q_item),
        .o_item_valid  (q_valid),
        .o_status      (q_stat)
    );

    assign full = q_stat.full;

    gcim_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (q_item),
        .i_item_valid(q_valid),
        .i_extent_x  (r_extent_x),
        .i_extent_y  (r_extent_y),
        .i_map       (r_map),
        .i_pop       (pop),
        .o_take      (take),
        .o_empty     (empty),
        .o_index_out (o_index_out),
        .o_x_out     (o_x_out),
        .o_y_out     (o_y_out),
        .o_z_out     (o_z_out)
    );

    // checks
    a_map_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(n_map.use_bits) == int'(nb[0]) + int'(nb[1]) + int'(nb[2]))
        else $error("interleave map slot count differs from dimension bits");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> q_stat.count == (gcim_pkg::QAW+1)'(gcim_pkg::QDEPTH))
        else $error("queue full flag without a full count");

    a_queue_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && q_stat.empty && !take) |=> !q_stat.empty)
        else $error("pushed beat lost while the back end stalled");

endmodule
`default_nettype wire

>>> test/tb_grid_coord_index_mapper.sv
// Testbench for the grid coordinate / linear index mapper: scoreboarded random and directed beats.
`default_nettype none
module tb_grid_coord_index_mapper;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 64;
    localparam int MAXDB = 10;
    localparam longint LIMIT = 2_000_000;

    typedef struct {
        logic [gcim_pkg::IW-1:0] index;
        logic [gcim_pkg::CW-1:0] x;
        logic [gcim_pkg::CW-1:0] y;
        logic [gcim_pkg::CW-1:0] z;
    } t_coord_result;

    // Expected mappings, oldest first, and the mapper configuration they use
    class mapping_scoreboard;
        t_coord_result pending[$];
        logic          mode;
        logic [gcim_pkg::EW-1:0] ext_x, ext_y, ext_z;
        int            errors;

        function int log2_cap(input logic [gcim_pkg::EW-1:0] n);
            int b;
            b = 0;
            while (n > 1) begin
                n = n >> 1;
                b++;
            end
            return (b > MAXDB) ? MAXDB : b;
        endfunction

        // Work out the mapping of one accepted beat
        function void note_beat(input logic op, input logic [gcim_pkg::CW-1:0] cx,
                                input logic [gcim_pkg::CW-1:0] cy,
                                input logic [gcim_pkg::CW-1:0] cz,
                                input logic [gcim_pkg::IW-1:0] li);
            t_coord_result r;
            logic [gcim_pkg::CW-1:0] c[3];
            logic [31:0]   p[3];
            logic [63:0]   v;
            logic [31:0]   q, nx, ny;
            int            nb[3], nmax, pos;
            r = '{default: '0};
            p[0] = 0; p[1] = 0; p[2] = 0;
            c[0] = cx; c[1] = cy; c[2] = cz;
            if (mode != gcim_pkg::MODE_MORTON) begin
                if (op == gcim_pkg::OP_TO_INDEX) begin
                    v = (64'(cz) * ext_y + cy) * ext_x + cx;
                    r.index = v[gcim_pkg::IW-1:0];
                end else begin
                    nx = (ext_x == 0) ? 1 : 32'(ext_x);
                    ny = (ext_y == 0) ? 1 : 32'(ext_y);
                    q = 32'(li);
                    p[0] = q % nx; q = q / nx;
                    p[1] = q % ny; q = q / ny;
                    p[2] = q;
                end
            end else begin
                nb[0] = log2_cap(ext_x);
                nb[1] = log2_cap(ext_y);
                nb[2] = log2_cap(ext_z);
                nmax = nb[0];
                if (nb[1] > nmax) nmax = nb[1];
                if (nb[2] > nmax) nmax = nb[2];
                pos = 0;
                v = 0;
                for (int b = 0; b < nmax; b++) begin
                    for (int d = 0; d < 3; d++) begin
                        if (b < nb[d]) begin
                            if (op == gcim_pkg::OP_TO_INDEX) begin
                                if (c[d][b]) v[pos] = 1'b1;
                            end else if (pos < gcim_pkg::IW && li[pos]) begin
                                p[d][b] = 1'b1;
                            end
                            pos++;
                        end
                    end
                end
                if (op == gcim_pkg::OP_TO_INDEX) r.index = v[gcim_pkg::IW-1:0];
            end
            if (op != gcim_pkg::OP_TO_INDEX) begin
                r.x = p[0][gcim_pkg::CW-1:0];
                r.y = p[1][gcim_pkg::CW-1:0];
                r.z = p[2][gcim_pkg::CW-1:0];
            end
            pending.push_back(r);
        endfunction

        task report(input string what, input logic [63:0] got,
                    input logic [63:0] want);
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        // Compare one popped result with the oldest expectation
        task check_result(input logic [gcim_pkg::IW-1:0] idx,
                          input logic [gcim_pkg::CW-1:0] x,
                          input logic [gcim_pkg::CW-1:0] y,
                          input logic [gcim_pkg::CW-1:0] z);
            t_coord_result e;
            if (pending.size() == 0) begin
                report("unexpected beat", 64'(idx), 64'd0);
                return;
            end
            e = pending.pop_front();
            if (idx !== e.index) report("index", 64'(idx), 64'(e.index));
            if (x !== e.x) report("x", 64'(x), 64'(e.x));
            if (y !== e.y) report("y", 64'(y), 64'(e.y));
            if (z !== e.z) report("z", 64'(z), 64'(e.z));
        endtask
    endclass

    logic          i_clk, i_rst_n;
    logic          push, full, empty, pop;
    logic          i_operation;
    logic [gcim_pkg::CW-1:0] i_coord_x, i_coord_y, i_coord_z;
    logic [gcim_pkg::IW-1:0] i_linear_index;
    logic [gcim_pkg::IW-1:0] o_index_out;
    logic [gcim_pkg::CW-1:0] o_x_out, o_y_out, o_z_out;
    logic          psel, penable, pwrite, pready;
    logic [3:0]    paddr;
    logic [31:0]   pwdata, prdata;

    mapping_scoreboard sb;
    int     send_idle_pct, recv_idle_pct;
    bit     hold_off;
    longint cycles;

    grid_coord_index_mapper uut (
        .i_clk, .i_rst_n, .push, .full, .i_operation, .i_coord_x, .i_coord_y,
        .i_coord_z, .i_linear_index, .empty, .pop, .o_index_out, .o_x_out,
        .o_y_out, .o_z_out, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
        .pready
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Cycle limit
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Result side: pop at random, check on accepted beats
    initial begin
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty)
                sb.check_result(o_index_out, o_x_out, o_y_out, o_z_out);
            @(negedge i_clk);
            pop <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Register write: setup then access, starting at the next falling edge
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            gcim_pkg::REG_MODE:  sb.mode = val[0];
            gcim_pkg::REG_EXT_X: sb.ext_x = val[gcim_pkg::EW-1:0];
            gcim_pkg::REG_EXT_Y: sb.ext_y = val[gcim_pkg::EW-1:0];
            default:             sb.ext_z = val[gcim_pkg::EW-1:0];
        endcase
    endtask

    task automatic set_grid(input logic m, input int ex, input int ey, input int ez);
        write_reg(gcim_pkg::REG_MODE, 32'(m));
        write_reg(gcim_pkg::REG_EXT_X, ex);
        write_reg(gcim_pkg::REG_EXT_Y, ey);
        write_reg(gcim_pkg::REG_EXT_Z, ez);
    endtask

    // Offer one beat until accepted, idling first at random; push is left
    // to the next beat or to drain
    task automatic send_beat(input logic op, input logic [gcim_pkg::CW-1:0] cx,
                             input logic [gcim_pkg::CW-1:0] cy,
                             input logic [gcim_pkg::CW-1:0] cz,
                             input logic [gcim_pkg::IW-1:0] li);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1; i_operation <= op;
        i_coord_x <= cx; i_coord_y <= cy; i_coord_z <= cz; i_linear_index <= li;
        do @(posedge i_clk); while (full);
        sb.note_beat(op, cx, cy, cz, li);
        @(negedge i_clk);
    endtask

    task automatic send_random();
        send_beat(1'($urandom_range(1)), gcim_pkg::CW'($urandom),
                  gcim_pkg::CW'($urandom), gcim_pkg::CW'($urandom),
                  gcim_pkg::IW'($urandom));
    endtask

    // Stop offering, wait for all results, then let the pipe settle
    task automatic drain();
        push <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 8) @(negedge i_clk);
    endtask

    function automatic int pow2_ext();
        return 1 << $urandom_range(MAXDB);
    endfunction

    initial begin
        sb = new();
        sb.errors = 0;
        sb.mode = 1'b0; sb.ext_x = 1; sb.ext_y = 1; sb.ext_z = 1;
        send_idle_pct = 15; recv_idle_pct = 64; hold_off = 0;
        i_rst_n = 1'b0; push = 1'b0; i_operation = 1'b0;
        i_coord_x = '0; i_coord_y = '0; i_coord_z = '0; i_linear_index = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset grid, then extremes in both modes
        send_beat(gcim_pkg::OP_TO_INDEX, 10'h3FF, 10'h3FF, 10'h3FF, '1);
        send_beat(1'b1, 0, 0, 0, '1);
        drain();
        set_grid(1'b0, 1024, 1024, 1024);
        send_beat(gcim_pkg::OP_TO_INDEX, 10'h3FF, 10'h3FF, 10'h3FF, 0);
        send_beat(gcim_pkg::OP_TO_INDEX, 0, 0, 0, '1);
        send_beat(1'b1, '1, '1, '1, '1);
        send_beat(1'b1, 0, 0, 0, 0);
        drain();
        // zero extents
        set_grid(1'b0, 0, 0, 0);
        send_beat(gcim_pkg::OP_TO_INDEX, 5, 7, 9, 0);
        send_beat(1'b1, 0, 0, 0, 30'h2AAA_AAAA);
        drain();
        // non-power-of-two extents, odd sizes
        set_grid(1'b0, 3, 5, 7);
        send_beat(gcim_pkg::OP_TO_INDEX, 2, 4, 6, 0);
        send_beat(1'b1, 0, 0, 0, 104);
        drain();
        set_grid(1'b1, 1024, 1024, 1024);
        send_beat(gcim_pkg::OP_TO_INDEX, 10'h3FF, 10'h3FF, 10'h3FF, 0);
        send_beat(gcim_pkg::OP_TO_INDEX, 10'h155, 10'h2AA, 10'h0F0, 0);
        send_beat(1'b1, 0, 0, 0, '1);
        send_beat(1'b1, 0, 0, 0, 30'h1555_5555);
        drain();
        // Morton with uneven, zero and non-power-of-two extents, one above 1024
        set_grid(1'b1, 2047, 0, 6);
        send_beat(gcim_pkg::OP_TO_INDEX, 10'h3FF, 10'h3FF, 10'h3FF, 0);
        send_beat(1'b1, 0, 0, 0, '1);
        drain();
        set_grid(1'b1, 2, 1024, 8);
        send_beat(gcim_pkg::OP_TO_INDEX, 10'h3FF, 10'h3FF, 10'h3FF, 0);
        send_beat(1'b1, 0, 0, 0, 30'h2AAA_AAAA);
        drain();

        // Long stall on the result side while beats keep coming; more beats
        // than the queue and pipeline hold, so the input stalls
        hold_off = 1;
        fork
            begin
                repeat (300) @(negedge i_clk);
                hold_off = 0;
            end
            repeat (120) send_random();
        join
        drain();

        // Random phases over several grid settings
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin send_idle_pct = 64; recv_idle_pct = 15; end
            if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
            for (int g = 0; g < 6; g++) begin
                if (g[0])
                    set_grid(1'b1, pow2_ext(), pow2_ext(), pow2_ext());
                else if (g == 2)
                    set_grid(1'b0, $urandom_range(2047), $urandom_range(2047),
                             $urandom_range(2047));
                else
                    set_grid(1'b0, $urandom_range(1, 1024), $urandom_range(1, 1024),
                             $urandom_range(1, 1024));
                repeat (66) send_random();
                drain();
            end
        end

        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

>>> grid_coord_index_mapper.f
rtl/gcim_pkg.sv
rtl/gcim_div_pipe.sv
rtl/gcim_front.sv
rtl/gcim_back.sv
rtl/grid_coord_index_mapper.sv
test/tb_grid_coord_index_mapper.sv
